FILE: sv/periodic_timer_wheel_assert.svh
// ---------------------------------------------------------------------------
// Periodic timer wheel assertion macros
// Concurrent assertion forms for the timer wheel datapath.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_WHEEL_ASSERT_SVH
`define PERIODIC_TIMER_WHEEL_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PTW_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PTW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ptw_pkg.sv
// ---------------------------------------------------------------------------
// Periodic timer wheel package
// Field widths, mode and status codes, controller/datapath interface types.
// ---------------------------------------------------------------------------
package ptw_pkg;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 4;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 3;

  localparam logic [MODE_W-1:0] MODE_REG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNREG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXPIRED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE_TICK  = 3'd4;

  // which result word goes into the output register
  typedef enum logic [1:0] {
    PUSH_NONE   = 2'd0,
    PUSH_SINGLE = 2'd1,
    PUSH_PEND   = 2'd2,
    PUSH_FINAL  = 2'd3
  } push_sel_e;

  typedef struct packed {
    logic      load;
    logic      div_start;
    logic      cur_adv;
    logic      scan_rst;
    logic      scan_inc;
    logic      mem_rd;
    logic      item_commit;
    logic      scan_commit;
    push_sel_e push;
  } ptw_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              reject;
    logic              div_busy;
    logic              hit;
    logic              pend_valid;
    logic              scan_last;
    logic              out_free;
  } ptw_sts_t;

endpackage

FILE: sv/ptw_div.sv
// ---------------------------------------------------------------------------
// Timer wheel divider
// Division by the slot count: reciprocal multiply, then the remainder.
// ---------------------------------------------------------------------------
module ptw_div #(
  parameter int WHEEL_SLOTS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ptw_pkg::PERIOD_W-1:0]         dividend_i,
  output logic                                 busy_o,
  output logic [$clog2((2**ptw_pkg::PERIOD_W-2)/WHEEL_SLOTS+1)-1:0] quo_o,
  output logic [$clog2(WHEEL_SLOTS)-1:0]       rem_o
);

  localparam int PW = ptw_pkg::PERIOD_W;
  localparam int SW = $clog2(WHEEL_SLOTS);
  localparam int RW = $clog2((2**PW-2)/WHEEL_SLOTS+1);
  localparam int SH = PW + SW;
  // ceil(2^SH / slots) gives the exact quotient for every PW-bit dividend
  localparam logic [PW:0] RECIP = (PW+1)'(((2**SH) + WHEEL_SLOTS - 1) / WHEEL_SLOTS);
  localparam logic [SW:0] DIV_X = (SW+1)'(WHEEL_SLOTS);

  logic           busy_q, busy_d;
  logic [RW-1:0]  quo_q;
  logic [SW-1:0]  x_lo_q;
  logic [SW-1:0]  rem_q;
  logic [2*PW:0]  prod;
  logic [RW+SW:0] qd;

  assign prod   = {{(PW+1){1'b0}}, dividend_i} * {{PW{1'b0}}, RECIP};
  assign qd     = {{(SW+1){1'b0}}, quo_q} * {{RW{1'b0}}, DIV_X};
  assign busy_d = start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // quotient registered on the start cycle, remainder in the cycle after; the remainder
  // is below the slot count, so the low bits of the difference are enough
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= prod[SH +: RW];
      x_lo_q <= dividend_i[SW-1:0];
    end
    if (busy_q) rem_q <= x_lo_q - qd[SW-1:0];
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/ptw_dpath.sv
// ---------------------------------------------------------------------------
// Timer wheel datapath
// Timer entry memory, active bits, wheel pointer, scan counter, output word.
// ---------------------------------------------------------------------------
`include "periodic_timer_wheel_assert.svh"

module ptw_dpath #(
  parameter int WHEEL_SLOTS = 8,
  parameter int MAX_TIMERS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptw_pkg::ptw_cmd_t               cmd_i,
  output ptw_pkg::ptw_sts_t               sts_o,
  input  logic [ptw_pkg::MODE_W-1:0]      mode_i,
  input  logic [ptw_pkg::ID_W-1:0]        timer_id_i,
  input  logic [ptw_pkg::PERIOD_W-1:0]    period_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptw_pkg::ID_W-1:0]        timer_id_res_o,
  output logic [ptw_pkg::STATUS_W-1:0]    status_o,
  output logic                            last_o
);

  localparam int SW = $clog2(WHEEL_SLOTS);
  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int RW = $clog2((2**ptw_pkg::PERIOD_W-2)/WHEEL_SLOTS+1);
  localparam logic [SW:0] SLOTS_X = (SW+1)'(WHEEL_SLOTS);

  typedef struct packed {
    logic [SW-1:0] slot;
    logic [RW-1:0] rounds;
    logic [RW-1:0] reload;
    logic [SW-1:0] off;
  } ent_t;

  function automatic logic [SW-1:0] slot_after(logic [SW-1:0] base, logic [SW-1:0] off);
    logic [SW:0] sum;
    sum = {1'b0, base} + {1'b0, off} + (SW+1)'(1);
    if (sum >= SLOTS_X) sum = sum - SLOTS_X;
    return sum[SW-1:0];
  endfunction

  // item word
  logic [ptw_pkg::MODE_W-1:0]   mode_q;
  logic [ptw_pkg::ID_W-1:0]     id_q;
  logic [ptw_pkg::PERIOD_W-1:0] period_q;
  logic [6:0]                   id_ext;
  logic                         id_ok;
  logic [IW-1:0]                item_idx;
  logic                         reject;

  // wheel and scan state
  logic [SW-1:0]         cur_q, cur_d;
  logic [IW-1:0]         scan_q, scan_d;
  logic [MAX_TIMERS-1:0] act_q, act_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [IW-1:0]         pend_id_q;

  // entry memory
  ent_t          ent_mem [MAX_TIMERS];
  ent_t          ent_q;
  ent_t          reg_ent, scan_ent, wr_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic          match, hit;

  // divider
  logic                         div_busy;
  logic [RW-1:0]                div_quo;
  logic [SW-1:0]                div_rem;
  logic [ptw_pkg::PERIOD_W-1:0] dividend;

  // output word
  logic                          out_valid_q, out_valid_d;
  logic [ptw_pkg::ID_W-1:0]      out_id_q;
  logic [ptw_pkg::STATUS_W-1:0]  out_status_q;
  logic                          out_last_q;
  logic                          out_free;

  // command decodes for the checks
  logic push_any;
  logic push_pend;
  logic scan_busy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      id_q     <= timer_id_i;
      period_q <= period_i;
    end
  end

  assign id_ext   = 7'(id_q);
  assign id_ok    = (id_ext < 7'(MAX_TIMERS));
  assign item_idx = id_ext[IW-1:0];
  assign reject   = (period_q == '0) || !id_ok;
  assign dividend = period_q - ptw_pkg::PERIOD_W'(1);

  ptw_div #(
    .WHEEL_SLOTS(WHEEL_SLOTS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .busy_o    (div_busy),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  // entry under scan; ent_q holds the word read for scan_q
  assign match = act_q[scan_q] && (ent_q.slot == cur_q);
  assign hit   = match && (ent_q.rounds == '0);

  always_comb begin
    scan_ent = ent_q;
    if (hit) begin
      scan_ent.slot   = slot_after(cur_q, ent_q.off);
      scan_ent.rounds = ent_q.reload;
    end else begin
      scan_ent.rounds = ent_q.rounds - RW'(1);
    end
  end

  always_comb begin
    reg_ent.slot   = slot_after(cur_q, div_rem);
    reg_ent.rounds = div_quo;
    reg_ent.reload = div_quo;
    reg_ent.off    = div_rem;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_q;
    wr_data = scan_ent;
    if (cmd_i.item_commit && (mode_q == ptw_pkg::MODE_REG) && !reject) begin
      wr_en   = 1'b1;
      wr_addr = item_idx;
      wr_data = reg_ent;
    end else if (cmd_i.scan_commit && match) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = cmd_i.scan_inc ? (scan_q + IW'(1)) : scan_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) ent_mem[wr_addr] <= wr_data;
    if (cmd_i.mem_rd) ent_q <= ent_mem[rd_addr];
  end

  always_comb begin
    cur_d        = cur_q;
    scan_d       = scan_q;
    act_d        = act_q;
    pend_valid_d = pend_valid_q;
    if (cmd_i.cur_adv) begin
      cur_d = (cur_q == SW'(WHEEL_SLOTS-1)) ? '0 : (cur_q + SW'(1));
    end
    if (cmd_i.scan_rst) begin
      scan_d       = '0;
      pend_valid_d = 1'b0;
    end else if (cmd_i.scan_inc) begin
      scan_d = scan_q + IW'(1);
    end
    if (cmd_i.item_commit) begin
      if ((mode_q == ptw_pkg::MODE_REG) && !reject) act_d[item_idx] = 1'b1;
      if ((mode_q == ptw_pkg::MODE_UNREG) && id_ok) act_d[item_idx] = 1'b0;
    end
    if (cmd_i.scan_commit && hit) pend_valid_d = 1'b1;
    if (cmd_i.push == ptw_pkg::PUSH_FINAL) pend_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      scan_q       <= '0;
      act_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      cur_q        <= cur_d;
      scan_q       <= scan_d;
      act_q        <= act_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // newest expiry is held back until the next one or the end of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_commit && hit) pend_id_q <= scan_q;
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.push != ptw_pkg::PUSH_NONE) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.push)
      ptw_pkg::PUSH_SINGLE: begin
        out_id_q   <= id_q;
        out_last_q <= 1'b1;
        if (mode_q == ptw_pkg::MODE_REG) begin
          out_status_q <= reject ? ptw_pkg::ST_REJECTED : ptw_pkg::ST_REGISTERED;
        end else begin
          out_status_q <= ptw_pkg::ST_REMOVED;
        end
      end
      ptw_pkg::PUSH_PEND: begin
        out_id_q     <= ptw_pkg::ID_W'(pend_id_q);
        out_status_q <= ptw_pkg::ST_EXPIRED;
        out_last_q   <= 1'b0;
      end
      ptw_pkg::PUSH_FINAL: begin
        out_last_q <= 1'b1;
        if (pend_valid_q) begin
          out_id_q     <= ptw_pkg::ID_W'(pend_id_q);
          out_status_q <= ptw_pkg::ST_EXPIRED;
        end else begin
          out_id_q     <= '0;
          out_status_q <= ptw_pkg::ST_IDLE_TICK;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign timer_id_res_o = out_id_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.reject     = reject;
    sts_o.div_busy   = div_busy;
    sts_o.hit        = hit;
    sts_o.pend_valid = pend_valid_q;
    sts_o.scan_last  = (scan_q == IW'(MAX_TIMERS-1));
    sts_o.out_free   = out_free;
  end

  assign push_any  = (cmd_i.push != ptw_pkg::PUSH_NONE);
  assign push_pend = (cmd_i.push == ptw_pkg::PUSH_PEND);
  assign scan_busy = cmd_i.scan_commit || cmd_i.mem_rd;

  `PTW_ASSERT_IMPLIES(a_push_needs_room, clk_i, rst_ni, push_any, out_free, "push into full output")
  `PTW_ASSERT_IMPLIES(a_pend_push_src, clk_i, rst_ni, push_pend, pend_valid_q && hit, "stray flush")
  `PTW_ASSERT_IMPLIES(a_commit_excl, clk_i, rst_ni, cmd_i.item_commit, !scan_busy, "commit in scan")
  `PTW_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, cmd_i.div_start, div_busy, "divider did not start")

endmodule

FILE: sv/ptw_ctrl.sv
// ---------------------------------------------------------------------------
// Timer wheel controller
// Sequences register, unregister and tick items over the datapath.
// ---------------------------------------------------------------------------
module ptw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output ptw_pkg::ptw_cmd_t cmd_o,
  input  ptw_pkg::ptw_sts_t sts_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_RESP = 7'b0001000,
    S_RD   = 7'b0010000,
    S_EV   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.push = ptw_pkg::PUSH_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.mode)
          ptw_pkg::MODE_REG: begin
            if (sts_i.reject) begin
              state_d = S_RESP;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          ptw_pkg::MODE_UNREG: state_d = S_RESP;
          ptw_pkg::MODE_TICK: begin
            cmd_o.cur_adv  = 1'b1;
            cmd_o.scan_rst = 1'b1;
            state_d        = S_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.push        = ptw_pkg::PUSH_SINGLE;
          cmd_o.item_commit = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EV;
      end
      S_EV: begin
        // a second expiry flushes the held one, which needs the output free
        if (!(sts_i.hit && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.scan_commit = 1'b1;
          if (sts_i.hit && sts_i.pend_valid) cmd_o.push = ptw_pkg::PUSH_PEND;
          if (sts_i.scan_last) begin
            state_d = S_FIN;
          end else begin
            cmd_o.scan_inc = 1'b1;
            cmd_o.mem_rd   = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.push = ptw_pkg::PUSH_FINAL;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/periodic_timer_wheel.sv
// ---------------------------------------------------------------------------
// Periodic timer wheel
// Hashed timing wheel for periodic timers, controller plus datapath.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one word per item: mode_i
// selects register, unregister or tick; timer_id_i and period_i go with it.
// Output channel (out_valid_o/out_ready_i) returns result words; last_o marks
// the final word of an item. Register and unregister give one word; a tick
// gives one word per expired timer in ascending id order, or a single
// no-expiry word.
// Items are handled one at a time. A register item splits the period into rounds
// and slot offset in a two-step division (reciprocal multiply, then the
// remainder); a rejected register and an unregister skip the division. A tick
// reads one timer entry per cycle while the output does not stall it, and writes
// back each entry that matches the current slot. Mode 3 is dropped with no
// result. The last result word shows in the same cycle as the next item can be
// taken.
// A new item is accepted while the previous result still sits in the output
// register; if the receiver stalls, the scan stops at the next word it must
// hand over and resumes when the register drains.
// Reset deactivates every timer and sets the wheel to slot 0; there is no
// clearing pass.
// ---------------------------------------------------------------------------
module periodic_timer_wheel #(
  parameter int WHEEL_SLOTS = 8,
  parameter int MAX_TIMERS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ptw_pkg::MODE_W-1:0]   mode_i,
  input  logic [ptw_pkg::ID_W-1:0]     timer_id_i,
  input  logic [ptw_pkg::PERIOD_W-1:0] period_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ptw_pkg::ID_W-1:0]     timer_id_res_o,
  output logic [ptw_pkg::STATUS_W-1:0] status_o,
  output logic                         last_o
);

  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ptw_dpath #(
    .WHEEL_SLOTS(WHEEL_SLOTS),
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .timer_id_i    (timer_id_i),
    .period_i      (period_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .timer_id_res_o(timer_id_res_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
